[hdl/l3si_pkg.sv]
// ----------------------------------------------------------------------------
// l3si_pkg
// Shared types and constants of the Layer III side-information parser.
// ----------------------------------------------------------------------------
package l3si_pkg;

    localparam int L3SI_QUEUE_DEPTH = 4;

    localparam int L3SI_IN_DATA_W  = 8;
    localparam int L3SI_IN_USER_W  = 2;
    localparam int L3SI_OUT_DATA_W = 16;
    localparam int L3SI_OUT_USER_W = 6;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       mono;
    } t_byte_item;

    typedef enum logic [4:0] {
        FC_MDB   = 5'd0,
        FC_PRIV  = 5'd1,
        FC_SCFSI = 5'd2,
        FC_P23   = 5'd3,
        FC_BIG   = 5'd4,
        FC_GAIN  = 5'd5,
        FC_SLEN1 = 5'd6,
        FC_SLEN2 = 5'd7,
        FC_WS    = 5'd8,
        FC_BT    = 5'd9,
        FC_MIX   = 5'd10,
        FC_TBL   = 5'd11,
        FC_SUB   = 5'd12,
        FC_R0    = 5'd13,
        FC_R1    = 5'd14,
        FC_PRE   = 5'd15,
        FC_SFS   = 5'd16,
        FC_C1    = 5'd17,
        FC_PART2 = 5'd18
    } t_field_code;

endpackage

[hdl/l3si_front.sv]
// ----------------------------------------------------------------------------
// l3si_front
// Input side: takes side-information bytes, marks frame starts and the
// channel mode, and holds them in a short queue for the parser.
// ----------------------------------------------------------------------------
module l3si_front
    import l3si_pkg::*;
#(
    parameter int QUEUE_DEPTH = L3SI_QUEUE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [L3SI_IN_DATA_W-1:0] i_s_tdata,  // data_byte
    input  logic [L3SI_IN_USER_W-1:0] i_s_tuser,  // frame_start, mono
    output logic                      o_item_valid,
    output t_byte_item                o_item,
    input  logic                      i_item_pop
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_byte_item    r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          push;
    logic          pop;
    t_byte_item    in_item;

    assign o_s_tready   = (r_count != CW'(QUEUE_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign push         = i_s_tvalid && o_s_tready;
    assign pop          = i_item_pop && o_item_valid;

    // The mode flag only counts on the first byte of a frame.
    always_comb begin
        in_item.data  = i_s_tdata;
        in_item.start = i_s_tuser[0];
        in_item.mono  = i_s_tuser[0] & i_s_tuser[1];
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (push) begin
            r_mem[r_wr_ptr] <= in_item;
        end
    end

endmodule

[hdl/l3si_back.sv]
// ----------------------------------------------------------------------------
// l3si_back
// Field parser: merges queued bytes into a bit window, cuts one field per cycle
// while output is free, emits derived values in follow-up cycles, and registers results.
// ----------------------------------------------------------------------------
module l3si_back
    import l3si_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_item_valid,
    input  t_byte_item                 i_item,
    output logic                       o_item_pop,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [L3SI_OUT_DATA_W-1:0] o_m_tdata,  // granule, channel, sub_index, field_value
    output logic [L3SI_OUT_USER_W-1:0] o_m_tuser,  // field_code, side_info_done
    output logic                       o_m_tlast   // last_of_byte
);

    typedef enum logic [4:0] {
        ST_MDB, ST_PRIV, ST_SCFSI, ST_P23, ST_BIG, ST_GAIN, ST_SFC, ST_WS, ST_BT,
        ST_MIX, ST_TBL, ST_SUB, ST_R0, ST_R1, ST_PRE, ST_SFS, ST_C1, ST_DONE
    } t_step;

    typedef enum logic [2:0] {
        AX_NONE, AX_SLEN2, AX_R0, AX_R1, AX_BT0, AX_PART2
    } t_aux;

    function automatic logic [3:0] f_width(input t_step s, input logic m);
        unique case (s)
            ST_MDB:  f_width = 4'd9;
            ST_PRIV: f_width = m ? 4'd5 : 4'd3;
            ST_P23:  f_width = 4'd12;
            ST_BIG:  f_width = 4'd9;
            ST_GAIN: f_width = 4'd8;
            ST_SFC:  f_width = 4'd4;
            ST_BT:   f_width = 4'd2;
            ST_TBL:  f_width = 4'd5;
            ST_SUB:  f_width = 4'd3;
            ST_R0:   f_width = 4'd4;
            ST_R1:   f_width = 4'd3;
            ST_SCFSI, ST_WS, ST_MIX, ST_PRE, ST_SFS, ST_C1: f_width = 4'd1;
            default: f_width = 4'd0;
        endcase
    endfunction

    function automatic logic f_more(input t_step s, input logic m, input logic [4:0] b);
        logic [3:0] fw;
        fw     = f_width(s, m);
        f_more = (fw != 4'd0) && ({1'b0, fw} <= b);
    endfunction

    function automatic logic [2:0] f_slen1(input logic [3:0] c);
        unique case (c)
            4'd0, 4'd1, 4'd2, 4'd3:     f_slen1 = 3'd0;
            4'd5, 4'd6, 4'd7:           f_slen1 = 3'd1;
            4'd8, 4'd9, 4'd10:          f_slen1 = 3'd2;
            4'd4, 4'd11, 4'd12, 4'd13:  f_slen1 = 3'd3;
            default:                    f_slen1 = 3'd4;
        endcase
    endfunction

    function automatic logic [1:0] f_slen2(input logic [3:0] c);
        unique case (c)
            4'd0, 4'd4:                 f_slen2 = 2'd0;
            4'd1, 4'd5, 4'd8, 4'd11:    f_slen2 = 2'd1;
            4'd2, 4'd6, 4'd9, 4'd12, 4'd14: f_slen2 = 2'd2;
            default:                    f_slen2 = 2'd3;
        endcase
    endfunction

    t_step       r_step, n_step;
    t_aux        r_aux, n_aux;
    logic [19:0] r_acc, n_acc;
    logic [4:0]  r_bits, n_bits;
    logic        r_gr, n_gr;
    logic        r_ch, n_ch;
    logic [1:0]  r_ix, n_ix;
    logic        r_mono, n_mono;
    logic [2:0]  r_slen1, n_slen1;
    logic [1:0]  r_slen2, n_slen2;
    logic [1:0]  r_bt, n_bt;
    logic        r_mix, n_mix;
    logic        r_ws, n_ws;
    logic        r_sv_gr, n_sv_gr;
    logic        r_sv_ch, n_sv_ch;
    logic        r_sv_done, n_sv_done;

    logic        r_out_valid;
    logic [4:0]  r_out_code;
    logic        r_out_gr;
    logic        r_out_ch;
    logic [1:0]  r_out_ix;
    logic [11:0] r_out_val;
    logic        r_out_last;
    logic        r_out_done;

    logic        res_fire;
    logic [4:0]  res_code;
    logic        res_gr;
    logic        res_ch;
    logic [1:0]  res_ix;
    logic [11:0] res_val;
    logic        res_last;
    logic        res_done;

    logic [3:0]  w;
    logic        can_field;
    logic        idle;
    logic        out_free;
    logic [4:0]  rem;
    logic [19:0] shifted;
    logic [11:0] v;
    logic [3:0]  r0;
    logic [6:0]  p2;
    logic [6:0]  s1w;
    logic [6:0]  s2w;
    logic        frame_end;

    assign w         = f_width(r_step, r_mono);
    assign can_field = (r_aux == AX_NONE) && (w != 4'd0) && ({1'b0, w} <= r_bits);
    assign idle      = (r_aux == AX_NONE) && !can_field;
    assign out_free  = !r_out_valid || i_m_tready;
    assign o_item_pop = idle && i_item_valid;

    assign rem     = r_bits - {1'b0, w};
    assign shifted = r_acc >> rem;
    assign v       = shifted[11:0] & ~(12'hFFF << w);
    assign r0      = ((r_bt == 2'd2) && !r_mix) ? 4'd8 : 4'd7;
    assign s1w     = {4'b0, r_slen1};
    assign s2w     = {5'b0, r_slen2};
    assign p2      = (r_bt == 2'd2) ? ((r_mix ? 7'd17 * s1w : 7'd18 * s1w) + 7'd18 * s2w)
                                    : (7'd11 * s1w + 7'd10 * s2w);
    assign frame_end = r_gr && (r_mono || r_ch);

    always_comb begin
        n_step    = r_step;
        n_aux     = r_aux;
        n_acc     = r_acc;
        n_bits    = r_bits;
        n_gr      = r_gr;
        n_ch      = r_ch;
        n_ix      = r_ix;
        n_mono    = r_mono;
        n_slen1   = r_slen1;
        n_slen2   = r_slen2;
        n_bt      = r_bt;
        n_mix     = r_mix;
        n_ws      = r_ws;
        n_sv_gr   = r_sv_gr;
        n_sv_ch   = r_sv_ch;
        n_sv_done = r_sv_done;
        res_fire  = 1'b0;
        res_code  = FC_MDB;
        res_gr    = 1'b0;
        res_ch    = 1'b0;
        res_ix    = 2'd0;
        res_val   = 12'd0;
        res_last  = 1'b0;
        res_done  = 1'b0;

        priority if (r_aux != AX_NONE) begin
            if (out_free) begin
                res_fire = 1'b1;
                res_gr   = r_sv_gr;
                res_ch   = r_sv_ch;
                n_aux    = AX_NONE;
                unique case (r_aux)
                    AX_SLEN2: begin
                        res_code = FC_SLEN2;
                        res_val  = {10'b0, r_slen2};
                    end
                    AX_R0: begin
                        res_code = FC_R0;
                        res_val  = {8'b0, r0};
                        n_aux    = AX_R1;
                    end
                    AX_R1: begin
                        res_code = FC_R1;
                        res_val  = {7'b0, 5'd20 - {1'b0, r0}};
                    end
                    AX_BT0: begin
                        res_code = FC_BT;
                    end
                    AX_PART2: begin
                        res_code = FC_PART2;
                        res_val  = {5'b0, p2};
                        res_done = r_sv_done;
                    end
                    default: begin
                        res_fire = 1'b0;
                    end
                endcase
                res_last = (n_aux == AX_NONE) && !f_more(r_step, r_mono, r_bits);
            end
        end else if (can_field) begin
            if (out_free) begin
                res_fire = 1'b1;
                res_gr   = r_gr;
                res_ch   = r_ch;
                res_val  = v;
                n_bits   = rem;
                n_acc    = r_acc & ~(20'hFFFFF << rem);
                n_sv_gr  = r_gr;
                n_sv_ch  = r_ch;
                unique case (r_step)
                    ST_MDB: begin
                        res_code = FC_MDB;
                        res_gr   = 1'b0;
                        res_ch   = 1'b0;
                        n_step   = ST_PRIV;
                    end
                    ST_PRIV: begin
                        res_code = FC_PRIV;
                        res_gr   = 1'b0;
                        res_ch   = 1'b0;
                        n_ch     = 1'b0;
                        n_ix     = 2'd0;
                        n_step   = ST_SCFSI;
                    end
                    ST_SCFSI: begin
                        res_code = FC_SCFSI;
                        res_gr   = 1'b0;
                        res_ix   = r_ix;
                        if (r_ix != 2'd3) begin
                            n_ix = r_ix + 2'd1;
                        end else begin
                            n_ix = 2'd0;
                            if (!r_mono && !r_ch) begin
                                n_ch = 1'b1;
                            end else begin
                                n_ch   = 1'b0;
                                n_gr   = 1'b0;
                                n_step = ST_P23;
                            end
                        end
                    end
                    ST_P23: begin
                        res_code = FC_P23;
                        n_step   = ST_BIG;
                    end
                    ST_BIG: begin
                        res_code = FC_BIG;
                        n_step   = ST_GAIN;
                    end
                    ST_GAIN: begin
                        res_code = FC_GAIN;
                        n_step   = ST_SFC;
                    end
                    ST_SFC: begin
                        n_slen1  = f_slen1(v[3:0]);
                        n_slen2  = f_slen2(v[3:0]);
                        res_code = FC_SLEN1;
                        res_val  = {9'b0, n_slen1};
                        n_aux    = AX_SLEN2;
                        n_step   = ST_WS;
                    end
                    ST_WS: begin
                        res_code = FC_WS;
                        n_ws     = v[0];
                        n_ix     = 2'd0;
                        if (v[0]) begin
                            n_step = ST_BT;
                        end else begin
                            n_mix  = 1'b0;
                            n_step = ST_TBL;
                        end
                    end
                    ST_BT: begin
                        res_code = FC_BT;
                        n_bt     = v[1:0];
                        n_step   = ST_MIX;
                    end
                    ST_MIX: begin
                        res_code = FC_MIX;
                        n_mix    = v[0];
                        n_ix     = 2'd0;
                        n_step   = ST_TBL;
                    end
                    ST_TBL: begin
                        res_code = FC_TBL;
                        res_ix   = r_ix;
                        if (r_ix < (r_ws ? 2'd1 : 2'd2)) begin
                            n_ix = r_ix + 2'd1;
                        end else begin
                            n_ix   = 2'd0;
                            n_step = r_ws ? ST_SUB : ST_R0;
                        end
                    end
                    ST_SUB: begin
                        res_code = FC_SUB;
                        res_ix   = r_ix;
                        if (r_ix < 2'd2) begin
                            n_ix = r_ix + 2'd1;
                        end else begin
                            n_ix   = 2'd0;
                            n_aux  = AX_R0;
                            n_step = ST_PRE;
                        end
                    end
                    ST_R0: begin
                        res_code = FC_R0;
                        n_step   = ST_R1;
                    end
                    ST_R1: begin
                        res_code = FC_R1;
                        n_bt     = 2'd0;
                        n_aux    = AX_BT0;
                        n_step   = ST_PRE;
                    end
                    ST_PRE: begin
                        res_code = FC_PRE;
                        n_step   = ST_SFS;
                    end
                    ST_SFS: begin
                        res_code = FC_SFS;
                        n_step   = ST_C1;
                    end
                    ST_C1: begin
                        res_code  = FC_C1;
                        n_aux     = AX_PART2;
                        n_sv_done = frame_end;
                        n_ix      = 2'd0;
                        if (!r_mono && !r_ch) begin
                            n_ch   = 1'b1;
                            n_step = ST_P23;
                        end else if (!r_gr) begin
                            n_ch   = 1'b0;
                            n_gr   = 1'b1;
                            n_step = ST_P23;
                        end else begin
                            n_ch   = 1'b0;
                            n_gr   = 1'b0;
                            n_step = ST_DONE;
                            n_acc  = 20'd0;
                            n_bits = 5'd0;
                        end
                    end
                    default: begin
                        res_fire = 1'b0;
                        n_step   = ST_DONE;
                    end
                endcase
                res_last = (n_aux == AX_NONE) && !f_more(n_step, r_mono, n_bits);
            end
        end else begin
            if (i_item_valid) begin
                if (i_item.start) begin
                    n_step  = ST_MDB;
                    n_gr    = 1'b0;
                    n_ch    = 1'b0;
                    n_ix    = 2'd0;
                    n_mono  = i_item.mono;
                    n_slen1 = 3'd0;
                    n_slen2 = 2'd0;
                    n_bt    = 2'd0;
                    n_mix   = 1'b0;
                    n_ws    = 1'b0;
                    n_acc   = {12'b0, i_item.data};
                    n_bits  = 5'd8;
                end else if (r_step != ST_DONE) begin
                    n_acc  = {r_acc[11:0], i_item.data};
                    n_bits = r_bits + 5'd8;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_MDB;
            r_aux       <= AX_NONE;
            r_acc       <= '0;
            r_bits      <= '0;
            r_gr        <= 1'b0;
            r_ch        <= 1'b0;
            r_ix        <= '0;
            r_mono      <= 1'b0;
            r_slen1     <= '0;
            r_slen2     <= '0;
            r_bt        <= '0;
            r_mix       <= 1'b0;
            r_ws        <= 1'b0;
            r_sv_gr     <= 1'b0;
            r_sv_ch     <= 1'b0;
            r_sv_done   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_step    <= n_step;
            r_aux     <= n_aux;
            r_acc     <= n_acc;
            r_bits    <= n_bits;
            r_gr      <= n_gr;
            r_ch      <= n_ch;
            r_ix      <= n_ix;
            r_mono    <= n_mono;
            r_slen1   <= n_slen1;
            r_slen2   <= n_slen2;
            r_bt      <= n_bt;
            r_mix     <= n_mix;
            r_ws      <= n_ws;
            r_sv_gr   <= n_sv_gr;
            r_sv_ch   <= n_sv_ch;
            r_sv_done <= n_sv_done;
            if (out_free) begin
                r_out_valid <= res_fire;
            end
            if (out_free && res_fire) begin
                r_out_code <= res_code;
                r_out_gr   <= res_gr;
                r_out_ch   <= res_ch;
                r_out_ix   <= res_ix;
                r_out_val  <= res_val;
                r_out_last <= res_last;
                r_out_done <= res_done;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_val, r_out_ix, r_out_ch, r_out_gr};
    assign o_m_tuser  = {r_out_done, r_out_code};
    assign o_m_tlast  = r_out_last;

    a_bits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= 5'd19)
        else $error("bit window holds more than 19 bits");

    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_DONE) |-> (r_bits == 5'd0))
        else $error("bits left in window after side information ended");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> r_out_last)
        else $error("end of side information not marked last of byte");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != ST_SCFSI) |-> (r_ix != 2'd3))
        else $error("index out of range outside scfsi");

endmodule

[hdl/layer3_side_info_parser.sv]
// ----------------------------------------------------------------------------
// layer3_side_info_parser
// MPEG-1 Layer III side-information field parser, top level.
// ----------------------------------------------------------------------------
// Side-information bytes enter on the slave stream and wait in a small queue.
// The parser takes one byte and then cuts one field per cycle while the
// output register is free, giving one result per cycle; derived values (slen2,
// implicit regions or block type, part2 length) each add one more result. A
// byte occupies the parser until it has given all its results (0 to 8,
// typically 1 to 3), and this single field extractor sets the rate.
// Results sit in an output register, so the next byte is taken while a
// result waits for the sink.
module layer3_side_info_parser
    import l3si_pkg::*;
#(
    parameter int QUEUE_DEPTH = L3SI_QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [L3SI_IN_DATA_W-1:0]  i_s_tdata,  // data_byte
    input  logic [L3SI_IN_USER_W-1:0]  i_s_tuser,  // frame_start, mono
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [L3SI_OUT_DATA_W-1:0] o_m_tdata,  // granule, channel, sub_index, field_value
    output logic [L3SI_OUT_USER_W-1:0] o_m_tuser,  // field_code, side_info_done
    output logic                       o_m_tlast   // last_of_byte
);

    logic       item_valid;
    t_byte_item item;
    logic       item_pop;

    l3si_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_item_valid(item_valid),
        .o_item      (item),
        .i_item_pop  (item_pop)
    );

    l3si_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_valid(item_valid),
        .i_item      (item),
        .o_item_pop  (item_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Layer III side-information parser.
// ----------------------------------------------------------------------------
// Side-information bytes go in on the slave stream. A behavioral parser in the
// bench cuts the same bit stream into fields, and every output transfer is
// checked against the oldest predicted field. The stimulus covers a stereo
// parse straight out of reset, restarts in mid-frame, bytes after the end of
// the side information, and then well-formed frames with random content,
// mixed with truncated frames and noise. The source and the sink idle at
// random except in the final part of the run.
module tb;

    import l3si_pkg::*;

    localparam int MAX_FIELDS_PER_BYTE = 12;
    localparam int STALL_LIMIT         = 2000;
    localparam int DRAIN_CYCLES        = 30;

    // Standard scalefac_compress tables, one nibble per code.
    localparam logic [63:0] SLEN1_PACKED = 64'h4433_3222_1113_0000;
    localparam logic [63:0] SLEN2_PACKED = 64'h3232_1321_3210_3210;

    typedef enum logic [4:0] {
        PS_MAIN_DATA_BEGIN,
        PS_PRIVATE,
        PS_SCFSI,
        PS_PART23,
        PS_BIG_VALUES,
        PS_GAIN,
        PS_SF_COMPRESS,
        PS_WINSWITCH,
        PS_BLOCKTYPE,
        PS_MIXED,
        PS_TABLE,
        PS_SUBGAIN,
        PS_REGION0,
        PS_REGION1,
        PS_PREFLAG,
        PS_SFSCALE,
        PS_COUNT1SEL,
        PS_DONE
    } t_parse_step;

    typedef enum logic [1:0] {
        FILL_ZERO,
        FILL_ONES,
        FILL_RANDOM
    } t_fill;

    typedef struct packed {
        logic [4:0]  code;
        logic        gr;
        logic        ch;
        logic [1:0]  sub;
        logic [11:0] value;
        logic        last;
        logic        done;
    } t_field_result;

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_s_tvalid = 1'b0;
    logic                       o_s_tready;
    logic [L3SI_IN_DATA_W-1:0]  i_s_tdata  = '0;  // data_byte
    logic [L3SI_IN_USER_W-1:0]  i_s_tuser  = '0;  // frame_start, mono
    logic                       o_m_tvalid;
    logic                       i_m_tready = 1'b0;
    logic [L3SI_OUT_DATA_W-1:0] o_m_tdata;        // granule, channel, sub_index, field_value
    logic [L3SI_OUT_USER_W-1:0] o_m_tuser;        // field_code, side_info_done
    logic                       o_m_tlast;        // last_of_byte

    // Parser state of the bench.
    logic [19:0]   bit_window;
    int unsigned   window_bits;
    t_parse_step   step;
    logic          cur_gr;
    logic          cur_ch;
    logic [1:0]    cur_idx;
    logic          is_mono;
    logic [2:0]    slen1;
    logic [1:0]    slen2;
    logic [1:0]    btype;
    logic          mixed;
    logic          wswitch;
    int            byte_fields;

    t_field_result expected_fields[$];
    logic          frame_bits[$];
    logic [7:0]    frame_bytes[$];

    logic          src_idle_on = 1'b1;
    logic          snk_idle_on = 1'b1;
    int            ready_hold  = 0;
    int            idle_cycles = 0;

    int            mismatches     = 0;
    int            fields_checked = 0;
    int            bytes_parsed   = 0;
    int            bytes_ignored  = 0;
    int            frames_sent    = 0;

    layer3_side_info_parser i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Field predictor
    // ------------------------------------------------------------------------
    task automatic clear_parser();
        bit_window  = '0;
        window_bits = 0;
        step        = PS_MAIN_DATA_BEGIN;
        cur_gr      = 1'b0;
        cur_ch      = 1'b0;
        cur_idx     = '0;
        is_mono     = 1'b0;
        slen1       = '0;
        slen2       = '0;
        btype       = '0;
        mixed       = 1'b0;
        wswitch     = 1'b0;
    endtask

    function automatic int unsigned step_width(input t_parse_step s, input logic mono_frame);
        case (s)
            PS_MAIN_DATA_BEGIN: return 9;
            PS_PRIVATE:         return mono_frame ? 5 : 3;
            PS_PART23:          return 12;
            PS_BIG_VALUES:      return 9;
            PS_GAIN:            return 8;
            PS_SF_COMPRESS:     return 4;
            PS_BLOCKTYPE:       return 2;
            PS_TABLE:           return 5;
            PS_SUBGAIN:         return 3;
            PS_REGION0:         return 4;
            PS_REGION1:         return 3;
            PS_SCFSI, PS_WINSWITCH, PS_MIXED,
            PS_PREFLAG, PS_SFSCALE, PS_COUNT1SEL: return 1;
            default:            return 0;
        endcase
    endfunction

    function automatic int unsigned part2_length();
        if (btype == 2'd2) begin
            return mixed ? 17 * slen1 + 18 * slen2 : 18 * slen1 + 18 * slen2;
        end
        return 11 * slen1 + 10 * slen2;
    endfunction

    task automatic emit(input t_field_code code, input logic gr, input logic ch,
                        input logic [1:0] sub, input int unsigned value, input logic done);
        t_field_result r;
        if (byte_fields >= MAX_FIELDS_PER_BYTE) return;
        r.code  = code;
        r.gr    = gr;
        r.ch    = ch;
        r.sub   = sub;
        r.value = value[11:0];
        r.last  = 1'b0;
        r.done  = done;
        expected_fields.push_back(r);
        byte_fields++;
    endtask

    task automatic cut_field(input int unsigned v);
        int unsigned r0;
        logic        closing;
        case (step)
            PS_MAIN_DATA_BEGIN: begin
                emit(FC_MDB, 1'b0, 1'b0, 2'd0, v, 1'b0);
                step = PS_PRIVATE;
            end
            PS_PRIVATE: begin
                emit(FC_PRIV, 1'b0, 1'b0, 2'd0, v, 1'b0);
                cur_ch  = 1'b0;
                cur_idx = '0;
                step    = PS_SCFSI;
            end
            PS_SCFSI: begin
                emit(FC_SCFSI, 1'b0, cur_ch, cur_idx, v, 1'b0);
                if (cur_idx != 2'd3) begin
                    cur_idx = cur_idx + 2'd1;
                end else begin
                    cur_idx = '0;
                    if (!is_mono && !cur_ch) begin
                        cur_ch = 1'b1;
                    end else begin
                        cur_ch = 1'b0;
                        cur_gr = 1'b0;
                        step   = PS_PART23;
                    end
                end
            end
            PS_PART23: begin
                emit(FC_P23, cur_gr, cur_ch, 2'd0, v, 1'b0);
                step = PS_BIG_VALUES;
            end
            PS_BIG_VALUES: begin
                emit(FC_BIG, cur_gr, cur_ch, 2'd0, v, 1'b0);
                step = PS_GAIN;
            end
            PS_GAIN: begin
                emit(FC_GAIN, cur_gr, cur_ch, 2'd0, v, 1'b0);
                step = PS_SF_COMPRESS;
            end
            PS_SF_COMPRESS: begin
                slen1 = SLEN1_PACKED[4 * v[3:0] +: 3];
                slen2 = SLEN2_PACKED[4 * v[3:0] +: 2];
                emit(FC_SLEN1, cur_gr, cur_ch, 2'd0, 32'(slen1), 1'b0);
                emit(FC_SLEN2, cur_gr, cur_ch, 2'd0, 32'(slen2), 1'b0);
                step = PS_WINSWITCH;
            end
            PS_WINSWITCH: begin
                wswitch = v[0];
                emit(FC_WS, cur_gr, cur_ch, 2'd0, v, 1'b0);
                cur_idx = '0;
                if (wswitch) begin
                    step = PS_BLOCKTYPE;
                end else begin
                    mixed = 1'b0;
                    step  = PS_TABLE;
                end
            end
            PS_BLOCKTYPE: begin
                btype = v[1:0];
                emit(FC_BT, cur_gr, cur_ch, 2'd0, v, 1'b0);
                step = PS_MIXED;
            end
            PS_MIXED: begin
                mixed = v[0];
                emit(FC_MIX, cur_gr, cur_ch, 2'd0, v, 1'b0);
                cur_idx = '0;
                step    = PS_TABLE;
            end
            PS_TABLE: begin
                emit(FC_TBL, cur_gr, cur_ch, cur_idx, v, 1'b0);
                if (cur_idx < (wswitch ? 2'd1 : 2'd2)) begin
                    cur_idx = cur_idx + 2'd1;
                end else begin
                    cur_idx = '0;
                    step    = wswitch ? PS_SUBGAIN : PS_REGION0;
                end
            end
            PS_SUBGAIN: begin
                emit(FC_SUB, cur_gr, cur_ch, cur_idx, v, 1'b0);
                if (cur_idx < 2'd2) begin
                    cur_idx = cur_idx + 2'd1;
                end else begin
                    r0      = (btype == 2'd2 && !mixed) ? 8 : 7;
                    cur_idx = '0;
                    emit(FC_R0, cur_gr, cur_ch, 2'd0, r0, 1'b0);
                    emit(FC_R1, cur_gr, cur_ch, 2'd0, 20 - r0, 1'b0);
                    step = PS_PREFLAG;
                end
            end
            PS_REGION0: begin
                emit(FC_R0, cur_gr, cur_ch, 2'd0, v, 1'b0);
                step = PS_REGION1;
            end
            PS_REGION1: begin
                emit(FC_R1, cur_gr, cur_ch, 2'd0, v, 1'b0);
                btype = 2'd0;
                emit(FC_BT, cur_gr, cur_ch, 2'd0, 0, 1'b0);
                step = PS_PREFLAG;
            end
            PS_PREFLAG: begin
                emit(FC_PRE, cur_gr, cur_ch, 2'd0, v, 1'b0);
                step = PS_SFSCALE;
            end
            PS_SFSCALE: begin
                emit(FC_SFS, cur_gr, cur_ch, 2'd0, v, 1'b0);
                step = PS_COUNT1SEL;
            end
            PS_COUNT1SEL: begin
                closing = cur_gr && (is_mono || cur_ch);
                emit(FC_C1, cur_gr, cur_ch, 2'd0, v, 1'b0);
                emit(FC_PART2, cur_gr, cur_ch, 2'd0, part2_length(), closing);
                cur_idx = '0;
                if (!is_mono && !cur_ch) begin
                    cur_ch = 1'b1;
                    step   = PS_PART23;
                end else if (!cur_gr) begin
                    cur_ch = 1'b0;
                    cur_gr = 1'b1;
                    step   = PS_PART23;
                end else begin
                    cur_ch = 1'b0;
                    cur_gr = 1'b0;
                    step   = PS_DONE;
                end
            end
            default: begin
                step = PS_DONE;
            end
        endcase
    endtask

    // Called once per accepted byte; clears parsed when the byte is ignored.
    task automatic predict_fields(input logic [7:0] data, input logic frame_start,
                                  input logic mono, output logic parsed);
        int unsigned   w;
        int unsigned   v;
        t_field_result tail;
        if (frame_start) begin
            clear_parser();
            is_mono = mono;
        end
        parsed = (step != PS_DONE);
        if (!parsed) return;
        bit_window  = {bit_window[11:0], data};
        window_bits = window_bits + 8;
        byte_fields = 0;
        w = step_width(step, is_mono);
        while (w != 0 && window_bits >= w && byte_fields < MAX_FIELDS_PER_BYTE) begin
            window_bits = window_bits - w;
            v = (32'(bit_window) >> window_bits) & ((32'd1 << w) - 1);
            bit_window = bit_window & 20'((32'd1 << window_bits) - 1);
            cut_field(v);
            w = step_width(step, is_mono);
        end
        if (step == PS_DONE) begin
            bit_window  = '0;
            window_bits = 0;
        end
        if (byte_fields > 0) begin
            tail = expected_fields.pop_back();
            tail.last = 1'b1;
            expected_fields.push_back(tail);
        end
    endtask

    // ------------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------------
    // Entered and left at a falling edge; tvalid stays high between bytes
    // unless a gap is inserted.
    task automatic send_byte(input logic [7:0] data, input logic frame_start,
                             input logic mono);
        logic parsed;
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= {mono, frame_start};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_fields(data, frame_start, mono, parsed);
        if (parsed) bytes_parsed++;
        else bytes_ignored++;
        @(negedge i_clk);
    endtask

    function automatic int unsigned pick(input int width, input t_fill fill);
        case (fill)
            FILL_ZERO: return 0;
            FILL_ONES: return (32'd1 << width) - 1;
            default:   return $urandom & ((32'd1 << width) - 1);
        endcase
    endfunction

    task automatic add_bits(input int unsigned value, input int width);
        for (int i = width - 1; i >= 0; i--) begin
            frame_bits.push_back(value[i]);
        end
    endtask

    task automatic build_frame(input logic mono, input t_fill fill);
        logic       ws;
        logic [1:0] bt;
        logic [7:0] b;
        frame_bits.delete();
        frame_bytes.delete();
        add_bits(pick(9, fill), 9);
        add_bits(pick(mono ? 5 : 3, fill), mono ? 5 : 3);
        add_bits(pick(mono ? 4 : 8, fill), mono ? 4 : 8);
        for (int gr = 0; gr < 2; gr++) begin
            for (int ch = 0; ch < (mono ? 1 : 2); ch++) begin
                add_bits(pick(12, fill), 12);
                add_bits(pick(9, fill), 9);
                add_bits(pick(8, fill), 8);
                add_bits(pick(4, fill), 4);
                ws = 1'(pick(1, fill));
                add_bits(32'(ws), 1);
                if (ws) begin
                    // Short blocks get extra weight so both mixed cases occur often.
                    if (fill == FILL_RANDOM && $urandom_range(0, 2) == 0) bt = 2'd2;
                    else bt = 2'(pick(2, fill));
                    add_bits(32'(bt), 2);
                    add_bits(pick(1, fill), 1);
                    add_bits(pick(10, fill), 10);
                    add_bits(pick(9, fill), 9);
                end else begin
                    add_bits(pick(15, fill), 15);
                    add_bits(pick(7, fill), 7);
                end
                add_bits(pick(3, fill), 3);
            end
        end
        for (int k = 0; k < frame_bits.size(); k += 8) begin
            for (int j = 0; j < 8; j++) begin
                b = {b[6:0], frame_bits[k + j]};
            end
            frame_bytes.push_back(b);
        end
    endtask

    task automatic send_frame(input logic mono, input t_fill fill, input int byte_count);
        build_frame(mono, fill);
        if (byte_count > frame_bytes.size()) byte_count = frame_bytes.size();
        for (int k = 0; k < byte_count; k++) begin
            send_byte(frame_bytes[k], k == 0, k == 0 ? mono : 1'($urandom_range(0, 1)));
        end
        frames_sent++;
    endtask

    function automatic t_fill random_fill();
        case ($urandom_range(0, 7))
            0:       return FILL_ZERO;
            1:       return FILL_ONES;
            default: return FILL_RANDOM;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sink side and result checking
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (snk_idle_on && ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            i_m_tready <= 1'b0;
        end else if (snk_idle_on && $urandom_range(0, 9) == 0) begin
            ready_hold <= $urandom_range(1, 19) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    function automatic string show(input t_field_result r);
        return $sformatf("code=%0d gr=%0d ch=%0d sub=%0d value=%0d last=%0d done=%0d",
                         r.code, r.gr, r.ch, r.sub, r.value, r.last, r.done);
    endfunction

    always @(posedge i_clk) begin : check_results
        t_field_result got;
        t_field_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.code  = o_m_tuser[4:0];
            got.done  = o_m_tuser[5];
            got.gr    = o_m_tdata[0];
            got.ch    = o_m_tdata[1];
            got.sub   = o_m_tdata[3:2];
            got.value = o_m_tdata[15:4];
            got.last  = o_m_tlast;
            if (expected_fields.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR %0t: unexpected transfer: %s", $time, show(got));
                end
            end else begin
                want = expected_fields.pop_front();
                fields_checked++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR %0t: field mismatch", $time);
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(got));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d fields outstanding",
                     STALL_LIMIT, expected_fields.size());
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Without any frame start the parser must treat the stream as stereo.
    task automatic test_stereo_from_reset();
        for (int k = 0; k < 4; k++) begin
            send_byte(8'hFF, 1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    // A frame start in the middle of the stereo parse drops it; the new frame
    // is mono with every field at its maximum.
    task automatic test_restart_mono_ones();
        send_frame(1'b1, FILL_ONES, 17);
    endtask

    task automatic test_bytes_after_done();
        send_byte(8'hA5, 1'b0, 1'b1);
        send_byte(8'h5A, 1'b0, 1'b0);
    endtask

    task automatic test_random_frames();
        int kind;
        while (bytes_parsed < 180) begin
            src_idle_on = ($urandom_range(0, 3) != 0);
            snk_idle_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                send_frame(1'($urandom_range(0, 1)), random_fill(), 32);
                repeat ($urandom_range(0, 2)) begin
                    send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
                end
            end else if (kind < 9) begin
                send_frame(1'($urandom_range(0, 1)), FILL_RANDOM, $urandom_range(1, 16));
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0,
                              1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    task automatic test_back_to_back_frames();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        send_frame(1'b0, FILL_RANDOM, 32);
        send_frame(1'b1, FILL_RANDOM, 17);
    endtask

    initial begin
        clear_parser();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_stereo_from_reset();
        test_restart_mono_ones();
        test_bytes_after_done();
        test_random_frames();
        test_back_to_back_frames();
        i_s_tvalid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d frames: %0d bytes parsed, %0d bytes ignored after side info.",
                 frames_sent, bytes_parsed, bytes_ignored);
        $display("Checked %0d fields, %0d mismatches.", fields_checked, mismatches);
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/l3si_pkg.sv
hdl/l3si_front.sv
hdl/l3si_back.sv
hdl/layer3_side_info_parser.sv
test/tb.sv
